@@ rtl/lfo_pkg.sv @@
// Shared types, register codes and constants of the low frequency oscillator.
// The sine quarter-wave table entries are computed here at elaboration.
// No dependencies.
package lfo_pkg;

  localparam int PHASE_BITS_DEF       = 24;
  localparam int SINE_TABLE_DEPTH_DEF = 256;

  // pi/2 in Q30, the argument scale of the sine series.
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // One full wave unit in Q2.12.
  localparam logic signed [13:0] W_ONE = 14'sd4096;

  localparam logic signed [19:0] SAT_MAX = 20'sd32767;
  localparam logic signed [19:0] SAT_MIN = -20'sd32768;

  // Bit positions in mode_flags.
  localparam int MODE_CLAMP_LO = 0;
  localparam int MODE_CLAMP_HI = 1;
  localparam int MODE_ADD      = 2;

  typedef enum logic [2:0] {
    CFG_FREQUENCY  = 3'd0,
    CFG_WAVEFORM   = 3'd1,
    CFG_AMPLITUDE  = 3'd2,
    CFG_OFFSET     = 3'd3,
    CFG_DEPTH      = 3'd4,
    CFG_CLAMP_LOW  = 3'd5,
    CFG_CLAMP_HIGH = 3'd6,
    CFG_MODE_FLAGS = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    WAVE_SINE     = 2'd0,
    WAVE_TRIANGLE = 2'd1,
    WAVE_SAW      = 2'd2,
    WAVE_SQUARE   = 2'd3
  } wave_e;

  typedef struct packed {
    logic signed [15:0] frequency;
    logic [1:0]         waveform;
    logic signed [15:0] amplitude;
    logic signed [15:0] offset;
    logic signed [15:0] depth;
    logic signed [15:0] clamp_low;
    logic signed [15:0] clamp_high;
    logic [2:0]         mode_flags;
  } cfg_t;

  // Datapath commands, at most one active per cycle.
  typedef struct packed {
    logic accept;     // take the item, start the phase step product
    logic phase_upd;  // advance the phase accumulator
    logic wave_ld;    // register the wave value
    logic amp_mul;    // amplitude times wave
    logic sample_ld;  // offset plus scaled wave, saturated
    logic depth_mul;  // sample times depth
    logic out_ld;     // clamps, additive step, load output register
  } cmd_t;

  function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
    logic signed [15:0] r;
    if (v > SAT_MAX) begin
      r = 16'sh7FFF;
    end else if (v < SAT_MIN) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  // Rounded Q12 sine of a Q30 angle by a seven-term Taylor series.
  // Only called with constants, so it folds away at elaboration.
  function automatic logic [12:0] sine_q12(input logic [63:0] x);
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + $signed(term);
    if (sum < 0) begin
      sum = 64'sd0;
    end
    sum = (sum + 64'sd131072) >>> 18;
    if (sum > 64'sd4096) begin
      sum = 64'sd4096;
    end
    return sum[12:0];
  endfunction

endpackage

@@ rtl/lfo_cfg.sv @@
// Configuration register bank of the oscillator.
// Depends on lfo_pkg for the register codes and the cfg_t bundle.
module lfo_cfg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  logic [2:0]       wr_index_i,
  input  logic [15:0]      wr_data_i,
  output lfo_pkg::cfg_t    cfg_o
);

  lfo_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frequency  <= 16'sd256;
      cfg_q.waveform   <= lfo_pkg::WAVE_SINE;
      cfg_q.amplitude  <= 16'sd4096;
      cfg_q.offset     <= 16'sd0;
      cfg_q.depth      <= 16'sd4096;
      cfg_q.clamp_low  <= 16'sh8000;
      cfg_q.clamp_high <= 16'sh7FFF;
      cfg_q.mode_flags <= 3'd0;
    end else if (wr_en_i) begin
      case (lfo_pkg::cfg_idx_e'(wr_index_i))
        lfo_pkg::CFG_FREQUENCY:  cfg_q.frequency  <= wr_data_i;
        lfo_pkg::CFG_WAVEFORM:   cfg_q.waveform   <= wr_data_i[1:0];
        lfo_pkg::CFG_AMPLITUDE:  cfg_q.amplitude  <= wr_data_i;
        lfo_pkg::CFG_OFFSET:     cfg_q.offset     <= wr_data_i;
        lfo_pkg::CFG_DEPTH:      cfg_q.depth      <= wr_data_i;
        lfo_pkg::CFG_CLAMP_LOW:  cfg_q.clamp_low  <= wr_data_i;
        lfo_pkg::CFG_CLAMP_HIGH: cfg_q.clamp_high <= wr_data_i;
        lfo_pkg::CFG_MODE_FLAGS: cfg_q.mode_flags <= wr_data_i[2:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/lfo_dp.sv @@
// Datapath of the oscillator: phase accumulator, wave shaper with the sine
// quarter-wave table, one shared multiplier, saturation, clamps, output register.
// Depends on lfo_pkg for cmd_t, cfg_t, codes and the table function.
module lfo_dp #(
  parameter int PHASE_BITS       = lfo_pkg::PHASE_BITS_DEF,
  parameter int SINE_TABLE_DEPTH = lfo_pkg::SINE_TABLE_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lfo_pkg::cmd_t      cmd_i,
  input  lfo_pkg::cfg_t      cfg_i,
  input  logic [23:0]        elapsed_time_i,
  input  logic signed [15:0] current_value_i,
  input  logic               current_present_i,
  output logic signed [15:0] lfo_sample_o,
  output logic signed [15:0] modulated_value_o
);

  localparam int SHIFT = 32 - PHASE_BITS;
  localparam int QBITS = PHASE_BITS - 2;
  localparam int IDX_W = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int SC_W  = QBITS + IDX_W;
  localparam logic [SC_W-1:0]       DEPTH_SC = SC_W'(SINE_TABLE_DEPTH);
  localparam logic [IDX_W-1:0]      IDX_MAX  = IDX_W'(SINE_TABLE_DEPTH);
  localparam logic [PHASE_BITS-1:0] HALF     = {1'b1, {(PHASE_BITS-1){1'b0}}};

  // Quarter-wave sine table, constant.
  logic [12:0] sine_rom [SINE_TABLE_DEPTH+1];

  for (genvar gi = 0; gi <= SINE_TABLE_DEPTH; gi++) begin : g_rom
    localparam logic [63:0] ANGLE = (lfo_pkg::HALF_PI_Q30 * 64'(gi)) / 64'(SINE_TABLE_DEPTH);
    assign sine_rom[gi] = lfo_pkg::sine_q12(ANGLE);
  end

  logic [PHASE_BITS-1:0] phase_q;
  logic signed [41:0]    prod_q;
  logic signed [13:0]    w_q;
  logic signed [15:0]    sample_q;
  logic signed [15:0]    cur_q;
  logic                  present_q;
  logic signed [15:0]    lfo_sample_q;
  logic signed [15:0]    modulated_value_q;

  // Shared multiplier operands.
  logic signed [24:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [41:0] prod;
  logic [15:0]        freq_pos;

  assign freq_pos = cfg_i.frequency[15] ? 16'd0 : cfg_i.frequency;

  always_comb begin
    if (cmd_i.amp_mul) begin
      mul_a = $signed({{9{cfg_i.amplitude[15]}}, cfg_i.amplitude});
      mul_b = $signed({{3{w_q[13]}}, w_q});
    end else if (cmd_i.depth_mul) begin
      mul_a = $signed({{9{sample_q[15]}}, sample_q});
      mul_b = $signed({cfg_i.depth[15], cfg_i.depth});
    end else begin
      mul_a = $signed({1'b0, elapsed_time_i});
      mul_b = $signed({1'b0, freq_pos});
    end
  end

  assign prod = mul_a * mul_b;

  // Product floored to Q4.12; the two scaled products fit in 20 bits.
  logic signed [41:0] prod_sh;
  logic signed [19:0] prod_q12;
  assign prod_sh  = prod_q >>> 12;
  assign prod_q12 = prod_sh[19:0];

  // Wave shaper.
  logic [PHASE_BITS-1:0] tri_d;
  logic [13:0]           tri_mag;
  logic [12:0]           saw_pos;
  logic [SC_W-1:0]       scaled;
  logic [IDX_W-1:0]      idx_raw;
  logic [IDX_W-1:0]      idx;
  logic [12:0]           sine_mag;
  logic signed [13:0]    w_tri;
  logic signed [13:0]    w_saw;
  logic signed [13:0]    w_sqr;
  logic signed [13:0]    w_sin;
  logic signed [13:0]    w_d;

  assign tri_d   = phase_q[PHASE_BITS-1] ? phase_q - HALF : HALF - phase_q;
  assign tri_mag = tri_d[PHASE_BITS-1 -: 14];
  assign w_tri   = 14'(15'sd4096 - $signed({1'b0, tri_mag}));
  assign saw_pos = phase_q[PHASE_BITS-1 -: 13];
  assign w_saw   = $signed({1'b0, saw_pos}) - lfo_pkg::W_ONE;
  assign w_sqr   = phase_q[PHASE_BITS-1] ? -lfo_pkg::W_ONE : lfo_pkg::W_ONE;

  // Quadrant from the top two phase bits, table index from the rest.
  assign scaled   = SC_W'(phase_q[QBITS-1:0]) * DEPTH_SC;
  assign idx_raw  = scaled[QBITS +: IDX_W];
  assign idx      = phase_q[PHASE_BITS-2] ? IDX_MAX - idx_raw : idx_raw;
  assign sine_mag = sine_rom[idx];
  assign w_sin    = phase_q[PHASE_BITS-1] ? -$signed({1'b0, sine_mag})
                                          : $signed({1'b0, sine_mag});

  always_comb begin
    case (lfo_pkg::wave_e'(cfg_i.waveform))
      lfo_pkg::WAVE_SINE:     w_d = w_sin;
      lfo_pkg::WAVE_TRIANGLE: w_d = w_tri;
      lfo_pkg::WAVE_SAW:      w_d = w_saw;
      lfo_pkg::WAVE_SQUARE:   w_d = w_sqr;
      default:                w_d = w_sin;
    endcase
  end

  // Sample and final stage: depth product saturated, clamps, additive step.
  logic signed [15:0] sample_d;
  logic signed [15:0] mod_v0;
  logic signed [15:0] mod_v1;
  logic signed [15:0] mod_v2;
  logic signed [15:0] mod_v3;

  assign sample_d = lfo_pkg::sat16(prod_q12 + $signed({{4{cfg_i.offset[15]}}, cfg_i.offset}));
  assign mod_v0   = lfo_pkg::sat16(prod_q12);
  assign mod_v1   = (cfg_i.mode_flags[lfo_pkg::MODE_CLAMP_LO] && mod_v0 < cfg_i.clamp_low)
                    ? cfg_i.clamp_low : mod_v0;
  // The upper clamp goes last, so it wins when the limits cross.
  assign mod_v2   = (cfg_i.mode_flags[lfo_pkg::MODE_CLAMP_HI] && mod_v1 > cfg_i.clamp_high)
                    ? cfg_i.clamp_high : mod_v1;
  assign mod_v3   = (cfg_i.mode_flags[lfo_pkg::MODE_ADD] && present_q)
                    ? lfo_pkg::sat16($signed({{4{cur_q[15]}}, cur_q})
                                     + $signed({{4{mod_v2[15]}}, mod_v2}))
                    : mod_v2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else if (cmd_i.phase_upd) begin
      phase_q <= phase_q + prod_q[SHIFT +: PHASE_BITS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept || cmd_i.amp_mul || cmd_i.depth_mul) begin
      prod_q <= prod;
    end
    if (cmd_i.accept) begin
      cur_q     <= current_value_i;
      present_q <= current_present_i;
    end
    if (cmd_i.wave_ld) begin
      w_q <= w_d;
    end
    if (cmd_i.sample_ld) begin
      sample_q <= sample_d;
    end
    if (cmd_i.out_ld) begin
      lfo_sample_q      <= sample_q;
      modulated_value_q <= mod_v3;
    end
  end

  assign lfo_sample_o      = lfo_sample_q;
  assign modulated_value_o = modulated_value_q;

endmodule

@@ rtl/lfo_ctrl.sv @@
// Controller of the oscillator: sequences one item through the datapath
// and owns the input stall and the output valid flag.
// Depends on lfo_pkg for cmd_t.
module lfo_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output lfo_pkg::cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PHASE,
    S_WAVE,
    S_AMP,
    S_SAMPLE,
    S_DEPTH,
    S_MOD
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_PHASE;
        end
      end
      S_PHASE: begin
        cmd_o.phase_upd = 1'b1;
        state_d         = S_WAVE;
      end
      S_WAVE: begin
        cmd_o.wave_ld = 1'b1;
        state_d       = S_AMP;
      end
      S_AMP: begin
        cmd_o.amp_mul = 1'b1;
        state_d       = S_SAMPLE;
      end
      S_SAMPLE: begin
        cmd_o.sample_ld = 1'b1;
        state_d         = S_DEPTH;
      end
      S_DEPTH: begin
        cmd_o.depth_mul = 1'b1;
        state_d         = S_MOD;
      end
      S_MOD: begin
        if (out_free) begin
          cmd_o.out_ld = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd_o))
    else $error("more than one datapath command active");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |=> (state_q == S_PHASE))
    else $error("accepted item did not start the phase update");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_ld |=> out_valid_o)
    else $error("loaded result not presented");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> !cmd_o.out_ld)
    else $error("output register overwritten while stalled");

  a_depth_after_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DEPTH) |-> ($past(state_q) == S_SAMPLE))
    else $error("depth product without a fresh sample");

endmodule

@@ rtl/lfo_modulation_source.sv @@
// Top level of the low frequency oscillator modulation source.
// Depends on lfo_pkg, lfo_cfg, lfo_ctrl and lfo_dp.
//
// Usage: each input item is one control tick carrying the elapsed time
// (unsigned Q0.24 seconds) and the target's current value with a present
// flag. For each item the block returns exactly one result item holding
// lfo_sample and modulated_value, both saturated signed Q4.12.
// Input and output channels use valid and stall: an item moves on a rising
// edge where valid is high and stall is low. Configuration registers are
// written through a separate valid/ready port that is always ready; write
// them only while no item is in flight.
// Sequencing: the controller walks each item through idle (accept),
// phase, wave, amp, sample, depth and mod, using the single shared
// multiplier (phase step, amplitude, depth) with a register after each
// product. The result is shown in the cycle after mod loads it; no new
// item is taken before then. A result waiting in the output register does
// not block the next item; only a second finished result waits for it.
// Reset clears the phase accumulator, sets each config register to its
// default (1 Hz sine, unity amplitude and depth, clamps and add off).
module lfo_modulation_source #(
  parameter int PHASE_BITS       = lfo_pkg::PHASE_BITS_DEF,
  parameter int SINE_TABLE_DEPTH = lfo_pkg::SINE_TABLE_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Input channel.
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [23:0]        elapsed_time_i,
  input  logic signed [15:0] current_value_i,
  input  logic               current_present_i,
  // Output channel.
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] lfo_sample_o,
  output logic signed [15:0] modulated_value_o,
  // Configuration write port.
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i
);

  lfo_pkg::cfg_t cfg;
  lfo_pkg::cmd_t cmd;

  // Register writes land in the next cycle, so the port never holds off.
  assign cfg_ready_o = 1'b1;

  lfo_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i && cfg_ready_o),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  lfo_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  lfo_dp #(
    .PHASE_BITS       (PHASE_BITS),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .cfg_i             (cfg),
    .elapsed_time_i    (elapsed_time_i),
    .current_value_i   (current_value_i),
    .current_present_i (current_present_i),
    .lfo_sample_o      (lfo_sample_o),
    .modulated_value_o (modulated_value_o)
  );

endmodule

@@ test/tb.sv @@
// Self-checking testbench for lfo_modulation_source: it predicts each tick's
// lfo_sample and modulated_value and checks them against the block's results.
// Depends on lfo_pkg and the RTL top level only.
module tb;
  import lfo_pkg::*;

  // The sine table has this many steps per quarter wave, plus one end point.
  localparam int          SINE_STEPS      = 256;
  // pi/2 in Q30, the angle scale of the table series.
  localparam bit [63:0]   QUARTER_TURN_Q30 = 64'd1686629713;
  // Cycles without any moved item before the run is abandoned.
  localparam int          WATCHDOG_LIMIT  = 2000;
  // Random phases after the directed part, and ticks per phase.
  localparam int          RAND_PHASES     = 9;
  localparam int          TICKS_PER_PHASE = 44;

  // The scoreboard keeps its own copy of the registers and the phase, works
  // out the result of every accepted tick and queues it until the block
  // delivers the matching result.
  class modulation_board;
    logic signed [15:0] freq_q, amp_q, offs_q, depth_q, clamp_lo_q, clamp_hi_q;
    wave_e              wave_q;
    logic [2:0]         mode_q;
    logic [23:0]        phase_q;
    int                 sine_lut [SINE_STEPS + 1];
    logic signed [15:0] sample_due [$];
    logic signed [15:0] value_due [$];
    int                 n_mismatch;

    function new();
      for (int i = 0; i <= SINE_STEPS; i++) begin
        sine_lut[i] = quarter_sine_q12(i);
      end
      freq_q     = 16'sd256;
      wave_q     = WAVE_SINE;
      amp_q      = 16'sd4096;
      offs_q     = 16'sd0;
      depth_q    = 16'sd4096;
      clamp_lo_q = 16'sh8000;
      clamp_hi_q = 16'sh7FFF;
      mode_q     = 3'd0;
      phase_q    = 24'd0;
      n_mismatch = 0;
    endfunction

    // Rounded Q12 sine of table step i, from a seven-term Taylor series in
    // Q30 integer arithmetic.
    function int quarter_sine_q12(int i);
      bit [63:0] x, x2, term;
      longint    acc;
      x    = (QUARTER_TURN_Q30 * 64'(i)) / 64'(SINE_STEPS);
      x2   = (x * x) >> 30;
      term = x;
      acc  = longint'(x);
      for (int n = 1; n <= 6; n++) begin
        term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) begin
          acc -= longint'(term);
        end else begin
          acc += longint'(term);
        end
      end
      if (acc < 0) begin
        acc = 0;
      end
      acc = (acc + 131072) >>> 18;
      if (acc > 4096) begin
        acc = 4096;
      end
      return int'(acc);
    endfunction

    function logic signed [15:0] clip16(longint v);
      if (v > 32767) begin
        return 16'sh7FFF;
      end
      if (v < -32768) begin
        return 16'sh8000;
      end
      return 16'(v);
    endfunction

    function void write_reg(cfg_idx_e idx, logic [15:0] data);
      case (idx)
        CFG_FREQUENCY:  freq_q     = data;
        CFG_WAVEFORM:   wave_q     = wave_e'(data[1:0]);
        CFG_AMPLITUDE:  amp_q      = data;
        CFG_OFFSET:     offs_q     = data;
        CFG_DEPTH:      depth_q    = data;
        CFG_CLAMP_LOW:  clamp_lo_q = data;
        CFG_CLAMP_HIGH: clamp_hi_q = data;
        CFG_MODE_FLAGS: mode_q     = data[2:0];
        default: ;
      endcase
    endfunction

    function void note_tick(logic [23:0] et, logic signed [15:0] cur, logic present);
      bit [63:0]          step;
      logic [23:0]        tri_dist;
      int                 idx;
      longint             w;
      logic signed [15:0] smp, val;
      // A negative rate leaves the phase where it is.
      step    = (freq_q > 0) ? (64'(et) * 64'(freq_q)) >> 8 : 64'd0;
      phase_q = phase_q + step[23:0];
      case (wave_q)
        WAVE_TRIANGLE: begin
          tri_dist = phase_q[23] ? phase_q - 24'h800000 : 24'h800000 - phase_q;
          w        = 4096 - longint'((64'(tri_dist) * 4) >> 12);
        end
        WAVE_SAW:    w = longint'(phase_q >> 11) - 4096;
        WAVE_SQUARE: w = phase_q[23] ? -4096 : 4096;
        default: begin
          // Quarter-wave lookup: odd quadrants run the table backwards,
          // the upper half of the cycle negates it.
          idx = int'(phase_q[21:14]);
          if (phase_q[22]) begin
            idx = SINE_STEPS - idx;
          end
          w = sine_lut[idx];
          if (phase_q[23]) begin
            w = -w;
          end
        end
      endcase
      smp = clip16(longint'(offs_q) + ((longint'(amp_q) * w) >>> 12));
      val = clip16((longint'(smp) * longint'(depth_q)) >>> 12);
      // The upper clamp comes last, so it wins when the limits cross.
      if (mode_q[MODE_CLAMP_LO] && val < clamp_lo_q) begin
        val = clamp_lo_q;
      end
      if (mode_q[MODE_CLAMP_HI] && val > clamp_hi_q) begin
        val = clamp_hi_q;
      end
      if (mode_q[MODE_ADD] && present) begin
        val = clip16(longint'(cur) + longint'(val));
      end
      sample_due.push_back(smp);
      value_due.push_back(val);
    endfunction

    task report(string what, logic signed [15:0] got, logic signed [15:0] want);
      n_mismatch++;
      $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
    endtask

    task check_result(logic signed [15:0] got_smp, logic signed [15:0] got_val);
      logic signed [15:0] want_smp, want_val;
      if (sample_due.size() == 0) begin
        report("result with no tick outstanding, lfo_sample", got_smp, 16'sd0);
        return;
      end
      want_smp = sample_due.pop_front();
      want_val = value_due.pop_front();
      if (got_smp !== want_smp) begin
        report("lfo_sample", got_smp, want_smp);
      end
      if (got_val !== want_val) begin
        report("modulated_value", got_val, want_val);
      end
    endtask

    function int pending();
      return sample_due.size();
    endfunction
  endclass

  // Every input of the block has a known value from time zero.
  logic               clk_i             = 1'b0;
  logic               rst_ni            = 1'b0;
  logic               in_valid_i        = 1'b0;
  logic [23:0]        elapsed_time_i    = '0;
  logic signed [15:0] current_value_i   = '0;
  logic               current_present_i = 1'b0;
  logic               out_stall_i       = 1'b0;
  logic               cfg_valid_i       = 1'b0;
  logic [2:0]         cfg_index_i       = '0;
  logic [15:0]        cfg_data_i        = '0;
  logic               in_stall_o, out_valid_o, cfg_ready_o;
  logic signed [15:0] lfo_sample_o, modulated_value_o;

  modulation_board board;
  // Register values that the next configuration pass writes, by index.
  logic [15:0]        cfg_plan [8];
  // While set, neither side idles, so the block runs at its full rate.
  bit                 quiet_phase = 1'b0;
  int                 stuck_cycles = 0;
  int                 stall_left = 0;
  bit                 stall_level = 1'b0;

  lfo_modulation_source u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .elapsed_time_i    (elapsed_time_i),
    .current_value_i   (current_value_i),
    .current_present_i (current_present_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .lfo_sample_o      (lfo_sample_o),
    .modulated_value_o (modulated_value_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Length of an idle or stall run: mostly short, at times medium, now and
  // then long enough to back up the whole pipeline.
  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return $urandom_range(1, 3);
    end
    if (r < 95) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(30, 80);
  endfunction

  // A full-range word that lands on the extremes and on zero fairly often.
  function automatic logic [15:0] pick_word();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3, 4, 5: return 16'($urandom_range(0, 16384) - 8192);
      default: return 16'($urandom);
    endcase
  endfunction

  // The monitor samples at the rising edge, before any of this edge's
  // nonblocking updates land, so it sees exactly what the block saw.
  // It feeds the scoreboard, checks results and runs the watchdog.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        board.write_reg(cfg_idx_e'(cfg_index_i), cfg_data_i);
      end
      if (in_valid_i && !in_stall_o) begin
        board.note_tick(elapsed_time_i, current_value_i, current_present_i);
      end
      if (out_valid_o && !out_stall_i) begin
        board.check_result(lfo_sample_o, modulated_value_o);
      end
    end
    if ((cfg_valid_i && cfg_ready_o) || (in_valid_i && !in_stall_o) ||
        (out_valid_o && !out_stall_i)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
    end
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // The receiver alternates runs of stalling and taking results. The level
  // is settled first and assigned once per edge.
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_level = ($urandom_range(0, 2) == 0);
      stall_left  = stall_level ? pick_len() : $urandom_range(1, 8);
    end else begin
      stall_left--;
    end
    out_stall_i <= stall_level && !quiet_phase;
  end

  // Offer one tick after a random gap and hold it until the block takes it.
  // Returns at the edge of acceptance with valid still high, so a following
  // tick without a gap keeps valid up without a glitch.
  task automatic send_tick(logic [23:0] et, logic [15:0] cur, logic present);
    int gap;
    gap = (quiet_phase || $urandom_range(0, 1) == 0) ? 0 : pick_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    elapsed_time_i    <= et;
    current_value_i   <= cur;
    current_present_i <= present;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Stop offering ticks and wait until every outstanding result is in.
  // The first edge lets the monitor note a tick taken at the last edge.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  // Write all eight registers from cfg_plan while the block is idle. Every
  // item yields a result, so idle means nothing is outstanding.
  task automatic apply_config();
    wait_idle();
    for (int k = 0; k < 8; k++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= 3'(k);
      cfg_data_i  <= cfg_plan[k];
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_tick();
    logic [23:0] et;
    int          r;
    r = $urandom_range(0, 9);
    case (r)
      0:          et = 24'd0;
      1:          et = 24'hFFFFFF;
      2, 3, 4, 5: et = 24'($urandom_range(0, 65535));
      default:    et = 24'($urandom);
    endcase
    send_tick(et, 16'($urandom), 1'($urandom_range(0, 1)));
  endtask

  // Random settings, extremes included. Waveform and mode words carry
  // random upper bits, which the block must drop.
  task automatic random_config();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0:       cfg_plan[CFG_FREQUENCY] = 16'h8000;
      1:       cfg_plan[CFG_FREQUENCY] = 16'h7FFF;
      2:       cfg_plan[CFG_FREQUENCY] = 16'h0000;
      3:       cfg_plan[CFG_FREQUENCY] = 16'($urandom) | 16'h8000;
      default: cfg_plan[CFG_FREQUENCY] = 16'($urandom_range(1, 32767));
    endcase
    cfg_plan[CFG_WAVEFORM]   = 16'($urandom);
    cfg_plan[CFG_AMPLITUDE]  = pick_word();
    cfg_plan[CFG_OFFSET]     = pick_word();
    cfg_plan[CFG_DEPTH]      = pick_word();
    cfg_plan[CFG_CLAMP_LOW]  = pick_word();
    cfg_plan[CFG_CLAMP_HIGH] = pick_word();
    cfg_plan[CFG_MODE_FLAGS] = 16'($urandom);
    apply_config();
  endtask

  initial begin
    board = new();
    // Reset values, so the first pass rewrites what the block already has.
    cfg_plan[CFG_FREQUENCY]  = 16'd256;
    cfg_plan[CFG_WAVEFORM]   = 16'(WAVE_SINE);
    cfg_plan[CFG_AMPLITUDE]  = 16'd4096;
    cfg_plan[CFG_OFFSET]     = 16'd0;
    cfg_plan[CFG_DEPTH]      = 16'd4096;
    cfg_plan[CFG_CLAMP_LOW]  = 16'h8000;
    cfg_plan[CFG_CLAMP_HIGH] = 16'h7FFF;
    cfg_plan[CFG_MODE_FLAGS] = 16'd0;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, starting from the reset settings (1 Hz sine). At 1 Hz
    // the phase step equals the elapsed time, so these walk known angles:
    // no time at all, almost a full cycle, then two quarter cycles.
    quiet_phase = 1'b1;
    send_tick(24'd0, 16'h7FFF, 1'b1);
    send_tick(24'hFFFFFF, 16'h8000, 1'b0);
    send_tick(24'h400000, 16'h0000, 1'b1);
    send_tick(24'h400000, 16'hFFFF, 1'b0);
    quiet_phase = 1'b0;

    // Every waveform at the highest rate, with junk above the waveform bits.
    cfg_plan[CFG_FREQUENCY] = 16'h7FFF;
    for (int k = 0; k < 4; k++) begin
      cfg_plan[CFG_WAVEFORM] = 16'hFFFC | 16'(wave_e'(k));
      apply_config();
      send_tick(24'hFFFFFF, 16'h1234, 1'b1);
      send_tick(24'h123456, 16'hEDCB, 1'b0);
    end

    // The most negative rate counts as zero, so the saw must not move.
    cfg_plan[CFG_FREQUENCY] = 16'h8000;
    cfg_plan[CFG_WAVEFORM]  = 16'(WAVE_SAW);
    apply_config();
    send_tick(24'hFFFFFF, 16'h0000, 1'b0);
    send_tick(24'h800000, 16'h0000, 1'b1);

    // Saturation: full amplitude and offset push the sample over the top,
    // and the most negative depth drives the modulation to the bottom.
    cfg_plan[CFG_FREQUENCY] = 16'd256;
    cfg_plan[CFG_WAVEFORM]  = 16'(WAVE_SQUARE);
    cfg_plan[CFG_AMPLITUDE] = 16'h7FFF;
    cfg_plan[CFG_OFFSET]    = 16'h7FFF;
    cfg_plan[CFG_DEPTH]     = 16'h8000;
    apply_config();
    send_tick(24'h000100, 16'h0000, 1'b0);
    send_tick(24'h800000, 16'h0000, 1'b0);

    // Both clamps on with the lower limit above the upper one: the upper
    // limit is applied last and wins. Junk sits above the mode bits.
    cfg_plan[CFG_AMPLITUDE]  = 16'd4096;
    cfg_plan[CFG_OFFSET]     = 16'd0;
    cfg_plan[CFG_DEPTH]      = 16'd4096;
    cfg_plan[CFG_CLAMP_LOW]  = 16'd1000;
    cfg_plan[CFG_CLAMP_HIGH] = 16'(-1000);
    cfg_plan[CFG_MODE_FLAGS] = 16'hFFF0 | 16'(1 << MODE_CLAMP_LO) | 16'(1 << MODE_CLAMP_HI);
    apply_config();
    send_tick(24'h100000, 16'h0000, 1'b0);

    // Additive mode with a large modulation: the sum saturates high, an
    // absent current value leaves the modulation alone, and a very negative
    // current value pulls the sum down.
    cfg_plan[CFG_OFFSET]     = 16'h7FFF;
    cfg_plan[CFG_DEPTH]      = 16'h7FFF;
    cfg_plan[CFG_CLAMP_LOW]  = 16'h8000;
    cfg_plan[CFG_CLAMP_HIGH] = 16'h7FFF;
    cfg_plan[CFG_MODE_FLAGS] = 16'(1 << MODE_CLAMP_LO) | 16'(1 << MODE_CLAMP_HI) |
                               16'(1 << MODE_ADD);
    apply_config();
    send_tick(24'h000010, 16'h7FFF, 1'b1);
    send_tick(24'h000010, 16'h7FFF, 1'b0);
    send_tick(24'h000010, 16'h8000, 1'b1);

    // Random phases, each under fresh settings. The second phase runs with
    // no idling on either side; the others pick that now and then. In the
    // middle of the fourth phase the sender holds off until the pipeline
    // has drained completely.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      random_config();
      quiet_phase = (ph == 1) || ($urandom_range(0, 5) == 0);
      for (int n = 0; n < TICKS_PER_PHASE; n++) begin
        if (ph == 3 && n == TICKS_PER_PHASE / 2) begin
          wait_idle();
        end
        random_tick();
      end
    end
    quiet_phase = 1'b0;

    // Drain, then keep the clock running so that anything stray shows.
    wait_idle();
    repeat (20) @(posedge clk_i);
    if (board.n_mismatch == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/lfo_pkg.sv
rtl/lfo_cfg.sv
rtl/lfo_dp.sv
rtl/lfo_ctrl.sv
rtl/lfo_modulation_source.sv
test/tb.sv
